// ===== design/anim_pkg.sv =====
// Shared types and constants for the animation easing sequencer.
package anim_pkg;

    localparam int RANGE_DEF    = 255;
    localparam int MS_TICKS_DEF = 1000;

    localparam int TICK_W   = 32;
    localparam int MS_W     = 16;
    localparam int RANGE_W  = 16;
    localparam int POS_W    = 8;
    localparam int PROD_W   = TICK_W + RANGE_W;
    localparam int STEP_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE     = 2'd2;

    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_IN     = 2'd1;
    localparam logic [1:0] CURVE_OUT    = 2'd2;

    localparam logic [1:0] MODE_POLL  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic [2:0] EX_IDLE    = 3'd0;
    localparam logic [2:0] EX_STARTED = 3'd1;
    localparam logic [2:0] EX_RUN     = 3'd2;
    localparam logic [2:0] EX_FRAME   = 3'd3;
    localparam logic [2:0] EX_ENDED   = 3'd4;

    // Divider command: start pulse and number of quotient bits to develop.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

// ===== design/animation_easing_sequencer.sv =====
// Top level of the animation easing sequencer: command decode, timing and easing.
//
// Usage. Each request on the slave stream is one command: s_axis_tuser carries the
// mode (poll, start or stop) and s_axis_tdata the free-running tick count. Every
// request yields exactly one result on the master stream: m_axis_tuser carries the
// execution state and m_axis_tdata the eased position. Registers (period, minimum
// frame spacing, curve) are written through the cfg channel, which is always ready;
// write them only while no request is in flight.
// Timing depends on the path taken: start, stop, idle and end polls go straight to
// the result, a poll with no frame due first accumulates and compares the ticks, a
// frame that ends the run adds the division of ticks into milliseconds and an eased
// frame adds the multiplications and the eased division. Both divisions use the
// shared radix-2 divider: 32 steps turn ticks into milliseconds and 16 steps form
// the eased quotient; a single 32x16 multiplier is used in turn for the operands.
// One request is processed at a time. The next request is accepted once the
// previous result has moved into the output register; when the receiver stalls,
// the result is held there and at most one further request is worked through and
// parked until it is free.
// Synchronous active-low reset returns the engine to idle with all counts, the
// position and the registers at zero; no result is pending after reset.
module animation_easing_sequencer #(
    parameter int RANGE    = anim_pkg::RANGE_DEF,
    parameter int MS_TICKS = anim_pkg::MS_TICKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [anim_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [anim_pkg::MS_W-1:0]     i_cfg_data,
    // Command stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] now_tick
    input  logic [1:0]                    s_axis_tuser,   // [1:0] mode
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] position
    output logic [2:0]                    m_axis_tuser    // [2:0] exec_state
);
    import anim_pkg::*;

    localparam logic [RANGE_W-1:0] RANGE_V = RANGE_W'(RANGE);
    localparam logic [RANGE_W-1:0] TPMS_V  = RANGE_W'(MS_TICKS);
    // The position as RANGE saturated to the 8-bit output.
    localparam logic [POS_W-1:0]   RANGE_SAT = (RANGE > 255) ? 8'hFF : POS_W'(RANGE);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_RUN,
        PH_END
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACC,
        ST_CMP,
        ST_TMS,
        ST_NEXT,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_EASE,
        ST_DONE
    } t_state;

    // Configuration registers
    logic [MS_W-1:0]   r_period;
    logic [MS_W-1:0]   r_min_frame;
    logic [1:0]        r_curve;

    // Engine state
    t_state            r_state;
    t_phase            r_phase;
    logic [TICK_W-1:0] r_last;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] r_next;
    logic [POS_W-1:0]  r_cur_pos;

    // Request and working registers
    logic [1:0]        r_mode;
    logic [TICK_W-1:0] r_now;
    logic [MS_W-1:0]   r_t;
    logic [TICK_W-1:0] r_den;
    logic [PROD_W-1:0] r_prod;
    logic [2:0]        r_res_state;
    logic [POS_W-1:0]  r_res_pos;

    // Output register
    logic              r_out_valid;
    logic [2:0]        r_out_state;
    logic [POS_W-1:0]  r_out_pos;

    // Multiplier operands and divider interface
    logic              n_mul_en;
    logic [TICK_W-1:0] n_mul_a;
    logic [RANGE_W-1:0] n_mul_b;
    logic              n_quad;
    logic [MS_W-1:0]   n_base;
    t_div_cmd          n_div_cmd;
    logic [TICK_W-1:0] n_div_rem;
    logic [TICK_W-1:0] n_div_dvd;
    logic [TICK_W-1:0] n_div_dsr;
    logic              div_done;
    logic [TICK_W-1:0] div_quot;

    // Final position from the eased quotient
    logic [RANGE_W-1:0] n_q;
    logic [RANGE_W-1:0] n_res;
    logic [RANGE_W-1:0] n_clamp;
    logic [POS_W-1:0]   n_pos;
    logic               n_out_free;

    // ------------------------------------------------------------------
    // Configuration port: always ready, writes beyond the list are dropped.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_min_frame <= '0;
            r_curve     <= CURVE_LINEAR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD:    r_period    <= i_cfg_data;
                CFG_MIN_FRAME: r_min_frame <= i_cfg_data;
                CFG_CURVE:     r_curve     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared multiplier and the divider.
    // ------------------------------------------------------------------
    always_comb begin
        n_quad  = (r_curve == CURVE_IN) || (r_curve == CURVE_OUT);
        // Ease-out works on the time still to go rather than the time gone.
        n_base  = (r_curve == CURVE_OUT) ? (r_period - r_t) : r_t;
        n_mul_en = 1'b0;
        n_mul_a  = '0;
        n_mul_b  = '0;
        case (r_state)
            ST_CMP: begin
                n_mul_en = 1'b1;
                n_mul_a  = TICK_W'(r_min_frame);
                n_mul_b  = TPMS_V;
            end
            ST_E0: begin
                n_mul_en = 1'b1;
                n_mul_a  = TICK_W'(r_period);
                n_mul_b  = n_quad ? r_period : RANGE_W'(1);
            end
            ST_E1: begin
                n_mul_en = 1'b1;
                n_mul_a  = TICK_W'(n_base);
                n_mul_b  = n_quad ? n_base : RANGE_W'(1);
            end
            ST_E2: begin
                n_mul_en = 1'b1;
                n_mul_a  = r_prod[TICK_W-1:0];
                n_mul_b  = RANGE_V;
            end
            default: ;
        endcase

        n_div_cmd.start = 1'b0;
        n_div_cmd.steps = '0;
        n_div_rem       = '0;
        n_div_dvd       = r_elapsed;
        n_div_dsr       = TICK_W'(TPMS_V);
        if (r_state == ST_CMP && r_elapsed > r_next) begin
            // Ticks to whole milliseconds: full 32-bit quotient.
            n_div_cmd.start = 1'b1;
            n_div_cmd.steps = STEP_W'(TICK_W);
        end else if (r_state == ST_E3) begin
            // The eased quotient never exceeds RANGE, so 16 steps suffice once the
            // upper part of the numerator seeds the remainder.
            n_div_cmd.start = 1'b1;
            n_div_cmd.steps = STEP_W'(RANGE_W);
            n_div_rem       = r_prod[PROD_W-1:RANGE_W];
            n_div_dvd       = {r_prod[RANGE_W-1:0], {(TICK_W-RANGE_W){1'b0}}};
            n_div_dsr       = r_den;
        end
    end

    anim_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (n_div_cmd),
        .i_rem_init (n_div_rem),
        .i_dividend (n_div_dvd),
        .i_divisor  (n_div_dsr),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (n_mul_en) begin
            r_prod <= n_mul_a * n_mul_b;
        end
    end

    // Position from the eased quotient, clamped to RANGE and then to 8 bits.
    always_comb begin
        n_q = div_quot[RANGE_W-1:0];
        if (r_curve == CURVE_OUT) begin
            n_res = (n_q > RANGE_V) ? '0 : (RANGE_V - n_q);
        end else begin
            n_res = n_q;
        end
        n_clamp = (n_res > RANGE_V) ? RANGE_V : n_res;
        n_pos   = (n_clamp > RANGE_W'(255)) ? 8'hFF : n_clamp[POS_W-1:0];
    end

    assign n_out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer: state, engine registers and the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_last      <= '0;
            r_elapsed   <= '0;
            r_next      <= '0;
            r_cur_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In ST_DONE the output register is reloaded by the state itself.
            if (r_out_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode  <= s_axis_tuser;
                        r_now   <= s_axis_tdata;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_res_state <= EX_IDLE;
                    r_res_pos   <= '0;
                    r_state     <= ST_DONE;
                    unique case (r_mode)
                        MODE_START: begin
                            r_phase <= PH_START;
                        end
                        MODE_STOP: begin
                            r_phase   <= PH_IDLE;
                            r_last    <= '0;
                            r_elapsed <= '0;
                            r_next    <= '0;
                            r_cur_pos <= '0;
                        end
                        MODE_POLL: begin
                            unique case (r_phase)
                                PH_START: begin
                                    r_res_state <= EX_STARTED;
                                    r_last      <= r_now;
                                    r_elapsed   <= '0;
                                    r_phase     <= PH_RUN;
                                end
                                PH_RUN: begin
                                    r_state <= ST_ACC;
                                end
                                PH_END: begin
                                    r_res_state <= EX_ENDED;
                                    r_res_pos   <= RANGE_SAT;
                                    r_phase     <= PH_IDLE;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_ACC: begin
                    // Tick difference taken modulo 2^32, and the sum wraps the same way.
                    r_elapsed <= r_elapsed + (r_now - r_last);
                    r_last    <= r_now;
                    r_state   <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_elapsed > r_next) begin
                        r_state <= ST_TMS;
                    end else begin
                        r_res_state <= EX_RUN;
                        r_res_pos   <= r_cur_pos;
                        r_state     <= ST_DONE;
                    end
                end
                ST_TMS: begin
                    if (div_done) begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    r_next <= r_elapsed + r_prod[TICK_W-1:0];
                    r_t    <= div_quot[MS_W-1:0];
                    if (div_quot < TICK_W'(r_period)) begin
                        r_state <= ST_E0;
                    end else begin
                        r_cur_pos   <= RANGE_SAT;
                        r_phase     <= PH_END;
                        r_res_state <= EX_FRAME;
                        r_res_pos   <= RANGE_SAT;
                        r_state     <= ST_DONE;
                    end
                end
                ST_E0: begin
                    r_state <= ST_E1;
                end
                ST_E1: begin
                    r_den   <= r_prod[TICK_W-1:0];
                    r_state <= ST_E2;
                end
                ST_E2: begin
                    r_state <= ST_E3;
                end
                ST_E3: begin
                    r_state <= ST_EASE;
                end
                ST_EASE: begin
                    if (div_done) begin
                        r_cur_pos   <= n_pos;
                        r_res_state <= EX_FRAME;
                        r_res_pos   <= n_pos;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_state <= r_res_state;
                        r_out_pos   <= r_res_pos;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;
    assign m_axis_tuser  = r_out_state;

endmodule

// ===== design/anim_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module anim_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  anim_pkg::t_div_cmd         i_cmd,
    input  logic [anim_pkg::TICK_W-1:0] i_rem_init,
    input  logic [anim_pkg::TICK_W-1:0] i_dividend,
    input  logic [anim_pkg::TICK_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [anim_pkg::TICK_W-1:0] o_quot
);
    import anim_pkg::*;

    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_dvd;
    logic [TICK_W-1:0] r_div;
    logic [TICK_W-1:0] r_quot;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TICK_W:0]   n_rem_sh;
    logic              n_ge;
    logic [TICK_W:0]   n_diff;

    // The partial remainder always stays below the divisor, so 33 bits cover the shift.
    always_comb begin
        n_rem_sh = {r_rem, r_dvd[TICK_W-1]};
        n_diff   = n_rem_sh - {1'b0, r_div};
        n_ge     = (n_rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
                r_rem  <= i_rem_init;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_diff[TICK_W-1:0] : n_rem_sh[TICK_W-1:0];
                r_dvd  <= {r_dvd[TICK_W-2:0], 1'b0};
                r_quot <= {r_quot[TICK_W-2:0], n_ge};
                r_cnt  <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== tb/tb_animation_easing_sequencer.sv =====
// Self-checking testbench for the animation easing sequencer, with its own engine predictor.
module tb_animation_easing_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import anim_pkg::*;

    // The package names three modes and three curves; the spare codes of both fields
    // are legal inputs and must be exercised too.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CURVE_SPARE = 2'd3;

    localparam logic [31:0] MS_TICKS = MS_TICKS_DEF;
    // Position reported at the end of a run, saturated to the 8-bit result field.
    localparam logic [7:0]  END_POSITION = (RANGE_DEF > 255) ? 8'd255 : 8'(RANGE_DEF);

    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned PHASES         = 12;
    localparam int unsigned PHASE_REQUESTS = 145;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] tick;
    } t_command;

    typedef struct packed {
        logic [2:0] state;
        logic [7:0] position;
    } t_report;

    // Engine phases as the predictor tracks them.
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ARMED,
        ENG_RUNNING,
        ENG_ENDING
    } t_engine_phase;

    // Block ports. Every input holds a known value from time zero.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] now_tick
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] position
    logic [2:0]  m_axis_tuser;          // [2:0] exec_state

    // Predictor copy of the registers and of the engine state, at their reset values.
    logic [15:0]   period_reg       = '0;
    logic [15:0]   min_frame_reg    = '0;
    logic [1:0]    curve_reg        = '0;
    t_engine_phase eng_phase        = ENG_IDLE;
    logic [31:0]   last_tick        = '0;
    logic [31:0]   elapsed_ticks    = '0;
    logic [31:0]   next_frame_tick  = '0;
    logic [7:0]    current_position = '0;

    t_command    queued_commands[$];    // requests waiting for the sender
    t_report     due_reports[$];        // predicted results, oldest first
    t_command    tx_current;            // request now offered on the slave stream
    int unsigned tx_gap;
    int unsigned rx_wait;
    int unsigned rx_hold_left = 0;
    logic        rx_hold_req  = 1'b0;
    bit          idle_on      = 1'b1;
    int unsigned queued_total = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    animation_easing_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Eased position for t_ms below the period, so the period is never zero here.
    // All terms are widened to 64 bits so that the squares cannot overflow.
    function automatic logic [7:0] eased_position(logic [31:0] t_ms);
        logic [63:0] t, p, r, d, q, res;
        t = {32'd0, t_ms};
        p = {48'd0, period_reg};
        r = 64'(RANGE_DEF);
        case (curve_reg)
            CURVE_IN: begin
                res = (t * t * r) / (p * p);
            end
            CURVE_OUT: begin
                d   = p - t;
                q   = (d * d * r) / (p * p);
                res = (q > r) ? 64'd0 : r - q;
            end
            default: begin
                // Linear, and the spare curve code falls back to it as well.
                res = (t * r) / p;
            end
        endcase
        if (res > r)
            res = r;
        return (res > 64'd255) ? 8'd255 : res[7:0];
    endfunction

    // Applies one command to the predicted engine and returns the report it causes.
    function automatic t_report animate_command(t_command cmd);
        t_report     rep;
        logic [31:0] t_ms;
        rep.state    = EX_IDLE;
        rep.position = '0;
        case (cmd.mode)
            MODE_START: begin
                // Re-arming keeps the frame trigger; only a stop clears it.
                eng_phase = ENG_ARMED;
            end
            MODE_STOP: begin
                eng_phase        = ENG_IDLE;
                last_tick        = '0;
                elapsed_ticks    = '0;
                next_frame_tick  = '0;
                current_position = '0;
            end
            MODE_POLL: begin
                case (eng_phase)
                    ENG_ARMED: begin
                        rep.state     = EX_STARTED;
                        last_tick     = cmd.tick;
                        elapsed_ticks = '0;
                        eng_phase     = ENG_RUNNING;
                    end
                    ENG_RUNNING: begin
                        rep.state = EX_RUN;
                        // Both the tick difference and the running count wrap at 2^32.
                        elapsed_ticks = elapsed_ticks + (cmd.tick - last_tick);
                        if (elapsed_ticks > next_frame_tick) begin
                            rep.state       = EX_FRAME;
                            t_ms            = elapsed_ticks / MS_TICKS;
                            next_frame_tick = elapsed_ticks
                                              + 32'(min_frame_reg) * MS_TICKS;
                            if (t_ms < {16'd0, period_reg}) begin
                                current_position = eased_position(t_ms);
                            end else begin
                                current_position = END_POSITION;
                                eng_phase        = ENG_ENDING;
                            end
                        end
                        last_tick    = cmd.tick;
                        rep.position = current_position;
                    end
                    ENG_ENDING: begin
                        rep.state    = EX_ENDED;
                        rep.position = END_POSITION;
                        eng_phase    = ENG_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // The spare mode code is ignored and reports idle.
            end
        endcase
        return rep;
    endfunction

    function automatic int unsigned draw_wait();
        return idle_on ? $urandom_range(11, 0) : 0;
    endfunction

    // Sender: offers queued requests in order, pausing a random number of cycles
    // after each one. The report is predicted at the edge that accepts a request.
    always @(posedge i_clk) begin
        t_command nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                due_reports.push_back(animate_command(tx_current));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (queued_commands.size() != 0) begin
                    nxt        = queued_commands.pop_front();
                    tx_current = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.tick;
                    s_axis_tuser  <= nxt.mode;
                    tx_gap = draw_wait();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering
    // requests and the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_req)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Receiver: checks every accepted report against the oldest prediction and then
    // withholds ready for a randomly drawn number of cycles.
    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_reports.size() == 0) begin
                    $error("unexpected result: exec_state %0d, position %0d",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    want = due_reports.pop_front();
                    if (m_axis_tuser !== want.state) begin
                        $error("exec_state mismatch: expected %0d, actual %0d",
                               want.state, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, m_axis_tdata);
                        error_count++;
                    end
                end
                rx_wait = draw_wait();
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (rx_hold_left == 0);
        end
    end

    task automatic queue_cmd(input logic [1:0] mode, input logic [31:0] tick);
        t_command cmd;
        cmd.mode = mode;
        cmd.tick = tick;
        queued_commands.push_back(cmd);
        queued_total++;
    endtask

    // Returns on a falling edge once every request has gone and every report is in.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (queued_commands.size() != 0 || s_axis_tvalid || due_reports.size() != 0);
    endtask

    // Register write; the predictor copy changes at the edge that takes the request.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PERIOD:    period_reg    = value;
            CFG_MIN_FRAME: min_frame_reg = value;
            CFG_CURVE:     curve_reg     = value[1:0];
            default: begin
            end
        endcase
    endtask

    // One animation: start, a started poll, then polls whose tick steps are sized so
    // that the run usually reaches its end within the sequence, followed by the end
    // report and an idle poll. Now and then a stop, a re-arm, the spare mode or a wild
    // tick breaks into the sequence.
    task automatic queue_run();
        logic [31:0] tick;
        int unsigned span, n_polls;
        tick    = $urandom;
        n_polls = $urandom_range(24, 4);
        span    = (int'(period_reg) * 1000) / n_polls;
        if (span < 200)
            span = 200;
        queue_cmd(MODE_START, $urandom);
        queue_cmd(MODE_POLL, tick);
        for (int i = 0; i < n_polls + 4; i++) begin
            if ($urandom_range(7, 0) == 0)
                tick += $urandom_range(999, 0);
            else
                tick += $urandom_range(span + span / 2, span / 2);
            if ($urandom_range(15, 0) == 0) begin
                case ($urandom_range(3, 0))
                    0: queue_cmd(MODE_STOP, $urandom);
                    1: queue_cmd(MODE_START, $urandom);
                    2: queue_cmd(MODE_UNUSED, $urandom);
                    default: tick = $urandom;
                endcase
            end
            queue_cmd(MODE_POLL, tick);
        end
    endtask

    // Cycle limit: a hung handshake or a missing report ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [31:0] t;
        logic [15:0] per, mfr;
        logic [1:0]  crv;
        int unsigned phase_first;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the registers at their reset values: a zero period,
        // so the first frame ends the run at once. Idle polls, a stop and the spare
        // mode all report idle, and the tick wraps between the started poll and the
        // frame.
        queue_cmd(MODE_POLL, 32'h0000_0000);
        queue_cmd(MODE_STOP, 32'hFFFF_FFFF);
        queue_cmd(MODE_UNUSED, 32'h5A5A_5A5A);
        queue_cmd(MODE_START, 32'hA5A5_A5A5);
        queue_cmd(MODE_POLL, 32'hFFFF_FF00);
        queue_cmd(MODE_POLL, 32'h0000_0010);
        queue_cmd(MODE_POLL, 32'h0000_0020);
        queue_cmd(MODE_POLL, 32'h0000_0030);
        wait_drained();

        // A short linear run: a frame, a poll with no time passed, a re-arm while
        // running that keeps the old frame trigger, then a backward step of one tick
        // that wraps the elapsed count back to zero without a frame.
        write_reg(CFG_PERIOD, 16'd10);
        write_reg(CFG_MIN_FRAME, 16'd0);
        write_reg(CFG_CURVE, {14'd0, CURVE_LINEAR});
        t = 32'h7FFF_FFFF;
        queue_cmd(MODE_START, t);
        queue_cmd(MODE_POLL, t);
        t += 32'd2501;
        queue_cmd(MODE_POLL, t);
        queue_cmd(MODE_POLL, t);
        queue_cmd(MODE_START, t);
        t = 32'h0000_1000;
        queue_cmd(MODE_POLL, t);
        t += 32'd1;
        queue_cmd(MODE_POLL, t);
        t -= 32'd1;
        queue_cmd(MODE_POLL, t);
        t += 32'd5000;
        queue_cmd(MODE_POLL, t);
        queue_cmd(MODE_UNUSED, ~t);
        t += 32'd20000;
        queue_cmd(MODE_POLL, t);
        queue_cmd(MODE_POLL, t);
        queue_cmd(MODE_START, t);
        queue_cmd(MODE_STOP, t);
        queue_cmd(MODE_POLL, t);

        // Random phases. The first few pin the register extremes; the rest favour
        // short periods so that runs finish within a few dozen polls. Each phase
        // begins only once the block has drained, so the registers change while idle.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    per = 16'hFFFF;
                    mfr = 16'd0;
                end
                1: begin
                    per = 16'hFFFF;
                    mfr = 16'hFFFF;
                end
                2: begin
                    per = 16'd0;
                    mfr = 16'hFFFF;
                end
                3: begin
                    per = 16'd1;
                    mfr = 16'd0;
                end
                default: begin
                    if ($urandom_range(3, 0) == 0)
                        per = 16'($urandom_range(16'hFFFF, 0));
                    else
                        per = 16'($urandom_range(400, 1));
                    if ($urandom_range(3, 0) == 0)
                        mfr = 16'($urandom_range(16'hFFFF, 0));
                    else
                        mfr = 16'($urandom_range(per / 3, 0));
                end
            endcase
            crv = 2'(ph % 4);
            write_reg(CFG_PERIOD, per);
            write_reg(CFG_MIN_FRAME, mfr);
            write_reg(CFG_CURVE, {14'd0, crv});
            // Every third phase runs without any idling on either side.
            idle_on     = (ph % 3 != 2);
            phase_first = queued_total;
            while (queued_total - phase_first < PHASE_REQUESTS)
                queue_run();
            if (ph == 1 || ph == 7) begin
                // Mid-phase, the receiver stops taking reports for a long stretch.
                do
                    @(negedge i_clk);
                while (queued_commands.size() > 90);
                @(posedge i_clk);
                rx_hold_req <= 1'b1;
                @(posedge i_clk);
                rx_hold_req <= 1'b0;
            end
        end

        // Let the slowest report time out before deciding; a stray one fails the run.
        wait_drained();
        repeat (80) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
